// ----- hw/rtl/sidc_pkg.sv -----
// ----------------------------------------------------------------------------
// sidc_pkg: shared definitions of the decimal text converter
// Widths, character codes and the item type that passes from the front end
// through the queue to the conversion back end.
// ----------------------------------------------------------------------------
package sidc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int BCD_W       = 4;
  // Decimal digits needed for the unsigned range of VALUE_WIDTH bits.
  localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_BITS    = DIGITS * BCD_W;
  localparam int STEP_W      = $clog2(VALUE_WIDTH);
  localparam int REM_W       = $clog2(DIGITS + 1);

  // The queue depth is a power of two.
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } item_t;

endpackage

// ----- hw/rtl/sidc_front.sv -----
// ----------------------------------------------------------------------------
// sidc_front: request intake and sign classification
// Accepts one signed value, splits it into a sign flag and an unsigned
// magnitude and holds the result until the queue takes it.
// ----------------------------------------------------------------------------
module sidc_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [sidc_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic                                 fifo_full_i,
  output logic                                 push_o,
  output sidc_pkg::item_t                      item_o
);

  logic            valid_q;
  sidc_pkg::item_t item_q;
  logic            accept;
  sidc_pkg::item_t item_d;

  assign push_o     = valid_q && !fifo_full_i;
  assign in_stall_o = valid_q && fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    item_d.neg = value_i[sidc_pkg::VALUE_WIDTH-1];
    item_d.mag = item_d.neg ? (~value_i + sidc_pkg::VALUE_WIDTH'(1)) : value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- hw/rtl/sidc_fifo.sv -----
// ----------------------------------------------------------------------------
// sidc_fifo: short request queue
// Decouples the intake from the conversion back end so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module sidc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sidc_pkg::item_t wr_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sidc_pkg::item_t rd_item_o
);

  sidc_pkg::item_t                  mem_q [sidc_pkg::FIFO_DEPTH];
  logic [sidc_pkg::PTR_W-1:0]       wr_ptr_q;
  logic [sidc_pkg::PTR_W-1:0]       rd_ptr_q;
  logic [sidc_pkg::CNT_W-1:0]       count_q;

  assign full_o    = (count_q == sidc_pkg::CNT_W'(sidc_pkg::FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + sidc_pkg::PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + sidc_pkg::PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + sidc_pkg::CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - sidc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ----- hw/rtl/sidc_back.sv -----
// ----------------------------------------------------------------------------
// sidc_back: shift-add-3 conversion and character output
// Converts one magnitude to BCD, one bit a cycle, then sends the sign and
// the significant digits through a registered output stage.
// ----------------------------------------------------------------------------
module sidc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sidc_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      text_char_o,
  output logic            last_char_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSign,
    StDigit
  } state_e;

  state_e                              state_q;
  logic [sidc_pkg::VALUE_WIDTH-1:0]    mag_q;
  logic [sidc_pkg::BCD_BITS-1:0]       bcd_q;
  logic                                neg_q;
  logic                                seen_q;
  logic [sidc_pkg::STEP_W-1:0]         step_q;
  logic [sidc_pkg::REM_W-1:0]          rem_q;
  logic                                out_valid_q;
  logic [7:0]                          text_q;
  logic                                last_q;

  logic [sidc_pkg::BCD_BITS-1:0]       adj;
  logic [sidc_pkg::BCD_W-1:0]          top;
  logic                                out_free;
  logic                                is_last;
  logic                                skip;

  always_comb begin
    for (int i = 0; i < sidc_pkg::DIGITS; i++) begin
      adj[i*sidc_pkg::BCD_W +: sidc_pkg::BCD_W] =
        (bcd_q[i*sidc_pkg::BCD_W +: sidc_pkg::BCD_W] >= 4'd5) ?
        bcd_q[i*sidc_pkg::BCD_W +: sidc_pkg::BCD_W] + 4'd3 :
        bcd_q[i*sidc_pkg::BCD_W +: sidc_pkg::BCD_W];
    end
  end

  assign top      = bcd_q[sidc_pkg::BCD_BITS-1 -: sidc_pkg::BCD_W];
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = (rem_q == sidc_pkg::REM_W'(1));
  assign skip     = !seen_q && (top == '0) && !is_last;
  assign pop_o    = (state_q == StIdle) && !empty_i;

  assign out_valid_o = out_valid_q;
  assign text_char_o = text_q;
  assign last_char_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mag_q       <= '0;
      bcd_q       <= '0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      step_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      text_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (!empty_i) begin
            mag_q   <= item_i.mag;
            neg_q   <= item_i.neg;
            bcd_q   <= '0;
            step_q  <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          bcd_q  <= {adj[sidc_pkg::BCD_BITS-2:0], mag_q[sidc_pkg::VALUE_WIDTH-1]};
          mag_q  <= {mag_q[sidc_pkg::VALUE_WIDTH-2:0], 1'b0};
          step_q <= step_q + sidc_pkg::STEP_W'(1);
          if (step_q == sidc_pkg::STEP_W'(sidc_pkg::VALUE_WIDTH - 1)) begin
            rem_q   <= sidc_pkg::REM_W'(sidc_pkg::DIGITS);
            seen_q  <= 1'b0;
            state_q <= neg_q ? StSign : StDigit;
          end
        end
        StSign: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            text_q      <= sidc_pkg::ASCII_MINUS;
            last_q      <= 1'b0;
            state_q     <= StDigit;
          end
        end
        StDigit: begin
          if (skip) begin
            bcd_q <= {bcd_q[sidc_pkg::BCD_BITS-sidc_pkg::BCD_W-1:0],
                      {sidc_pkg::BCD_W{1'b0}}};
            rem_q <= rem_q - sidc_pkg::REM_W'(1);
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            text_q      <= sidc_pkg::ASCII_ZERO + {4'b0000, top};
            last_q      <= is_last;
            seen_q      <= 1'b1;
            bcd_q       <= {bcd_q[sidc_pkg::BCD_BITS-sidc_pkg::BCD_W-1:0],
                            {sidc_pkg::BCD_W{1'b0}}};
            rem_q       <= rem_q - sidc_pkg::REM_W'(1);
            if (is_last) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed integer to decimal ASCII text
// The back end runs the shift-add-3 loop at one input bit per cycle, then
// drops one suppressed leading zero or sends one sign or digit per cycle,
// the sign and digits only while the output is not stalled. A two-entry
// queue lets the next request wait meanwhile.
// Reset is asynchronous and active low; it empties the queue and the output.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [sidc_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [7:0]                              text_char_o,
  output logic                                    last_char_o
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  sidc_pkg::item_t wr_item;
  sidc_pkg::item_t rd_item;

  sidc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .fifo_full_i (full),
    .push_o      (push),
    .item_o      (wr_item)
  );

  sidc_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_item_i (wr_item),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .rd_item_o (rd_item)
  );

  sidc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (rd_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

endmodule
